// ----- hdl/tksi_pkg.sv -----
// Shared types and operation codes for the top-k sorted insert table.
`default_nettype none

package tksi_pkg;

   localparam int VALUE_W = 64;
   localparam int COUNT_W = 5;
   localparam int INDEX_W = 4;
   localparam int FUNC_W  = 2;

   localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_READ   = 2'd2;

   typedef struct packed {
      logic [FUNC_W-1:0]  func;
      logic [VALUE_W-1:0] value;
      logic [INDEX_W-1:0] entry_index;
   } req_type;

   typedef struct packed {
      logic [COUNT_W-1:0] rank;
      logic               stored;
      logic [COUNT_W-1:0] count;
      logic [VALUE_W-1:0] entry_value;
   } rsp_type;

   // broadcast from the control to every cell
   typedef struct packed {
      logic               load;
      logic [VALUE_W-1:0] value;
   } bcast_type;

   // handed from one cell to the next one down
   typedef struct packed {
      logic               gt;
      logic [VALUE_W-1:0] entry;
   } link_type;

endpackage

`default_nettype wire

// ----- hdl/tksi_cell.sv -----
// One table slot: compares its entry with the new value and shifts locally.
`default_nettype none

module tksi_cell
   import tksi_pkg::*;
(
   input  wire logic      clock,
   input  wire bcast_type bcast,
   input  wire logic      cell_valid,
   input  wire link_type  up,
   output link_type       down
);

   logic [VALUE_W-1:0] entry_ff;
   logic [VALUE_W-1:0] entry_in;
   logic               gt;

   // strictly greater keeps its place; ties end up below the new value
   assign gt = cell_valid & (entry_ff > bcast.value);

   always_comb begin
      entry_in = entry_ff;
      if (bcast.load && !gt) begin
         if (up.gt) begin
            entry_in = bcast.value;   // this slot is the rank
         end else begin
            entry_in = up.entry;      // below the rank: shift down
         end
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign down.gt    = gt;
   assign down.entry = entry_ff;

endmodule

`default_nettype wire

// ----- hdl/top_k_sorted_insert_table.sv -----
// Top level of the top-k sorted insert table: control, cell row and ports.
`default_nettype none

//  channel   direction  handshake             payload / data
//  req       in         req_valid/req_stall   req_type: func, value, entry_index
//  rsp       out        rsp_valid/rsp_stall   rsp_type: rank, stored, count, entry_value
//  csr       in/out     psel/penable/pready   capacity at byte address 0
//
//  All cells compare in parallel and shift at the same edge, and the
//  response sits in one output register. A new request is taken every
//  cycle unless that register is full and stalled. Reset (synchronous)
//  empties the table and sets capacity to 16; entry storage is not
//  cleared, the count masks it.

module top_k_sorted_insert_table
   import tksi_pkg::*;
#(
   parameter int DEPTH = 16
)
(
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire req_type     req_payload,
   // response channel
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output rsp_type          rsp_payload,
   // register port
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [2:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);

   // only the first 31 slots can ever be in use (capacity is 5 bits)
   localparam int CAP_MAX = (DEPTH < 31) ? DEPTH : 31;
   localparam logic [COUNT_W-1:0] CAP_MAX_W = COUNT_W'(CAP_MAX);
   localparam logic [COUNT_W-1:0] CAP_RESET = 5'd16;

   function automatic logic [COUNT_W-1:0] eff_cap(input logic [COUNT_W-1:0] c);
      logic [COUNT_W-1:0] r;
      r = c;
      if (c == '0) begin
         r = COUNT_W'(1);
      end else if (c > CAP_MAX_W) begin
         r = CAP_MAX_W;
      end
      return r;
   endfunction

   logic [COUNT_W-1:0] capacity_ff, capacity_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   logic [COUNT_W-1:0] cap;
   logic               req_accept;
   logic               csr_write;
   logic [COUNT_W-1:0] new_cap;

   bcast_type          bcast;
   link_type           link [DEPTH+1];
   logic [DEPTH-1:0]   cell_valid;
   logic [DEPTH-1:0]   gt_vec;

   logic [COUNT_W-1:0] rank;
   logic               stored;
   logic [VALUE_W-1:0] read_data;

   assign cap        = eff_cap(capacity_ff);
   assign req_stall  = rsp_valid_ff & rsp_stall;
   assign req_accept = req_valid & ~req_stall;

   // APB: zero-wait, decoded on word address
   assign pready    = 1'b1;
   assign csr_write = psel & penable & pwrite & (paddr[2] == 1'b0);
   assign prdata    = (paddr[2] == 1'b0) ? {{(32-COUNT_W){1'b0}}, capacity_ff} : '0;
   assign new_cap   = eff_cap(pwdata[COUNT_W-1:0]);

   // ---------------------------------------------------------------- cell row
   assign link[0].gt    = 1'b1;   // virtual slot above the head
   assign link[0].entry = '0;

   assign bcast.value = req_payload.value;
   assign bcast.load  = req_accept & (req_payload.func == FUNC_INSERT) & stored;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      assign cell_valid[i] = (i < int'(count_ff));
      assign gt_vec[i]     = link[i+1].gt;

      tksi_cell u_cell (
         .clock      (clock),
         .bcast      (bcast),
         .cell_valid (cell_valid[i]),
         .up         (link[i]),
         .down       (link[i+1])
      );
   end

   // greater-than flags form a run of ones from the head; the rank is
   // where the run ends
   always_comb begin
      rank = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (link[i].gt && !gt_vec[i]) begin
            rank = rank | COUNT_W'(i);
         end
      end
      if (gt_vec[DEPTH-1]) begin
         rank = COUNT_W'(DEPTH);
      end
   end

   assign stored = (rank < cap);

   always_comb begin
      read_data = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (cell_valid[i] && (int'(req_payload.entry_index) == i)) begin
            read_data = read_data | link[i+1].entry;
         end
      end
   end

   // ---------------------------------------------------------------- control
   always_comb begin
      capacity_in  = capacity_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      rsp_in       = rsp_ff;

      if (csr_write) begin
         capacity_in = pwdata[COUNT_W-1:0];
         if (count_ff > new_cap) begin
            count_in = new_cap;
         end
      end

      if (req_accept) begin
         rsp_valid_in       = 1'b1;
         rsp_in.rank        = '0;
         rsp_in.stored      = 1'b0;
         rsp_in.entry_value = '0;
         case (req_payload.func)
            FUNC_INSERT: begin
               rsp_in.rank   = rank;
               rsp_in.stored = stored;
               if (stored && (count_ff < cap)) begin
                  count_in = count_ff + COUNT_W'(1);
               end
            end
            FUNC_CLEAR: begin
               count_in = '0;
            end
            FUNC_READ: begin
               rsp_in.entry_value = read_data;
            end
            default: begin
            end
         endcase
         rsp_in.count = count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff  <= CAP_RESET;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         capacity_ff  <= capacity_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

`ifndef SYNTHESIS
   // count stays within the effective capacity
   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      count_ff <= cap)
      else $error("count above capacity");

   // stored entries stay sorted: greater-than flags are a run from the head
   a_sorted: assert property (@(posedge clock) disable iff (reset)
      req_valid |-> ((gt_vec & (gt_vec + DEPTH'(1))) == '0))
      else $error("table out of order");

   // every accepted request yields a response next cycle
   a_rsp: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> rsp_valid_ff)
      else $error("response missing");

   // a response held under stall keeps its payload
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=> $stable(rsp_ff))
      else $error("response changed while stalled");
`endif

endmodule

`default_nettype wire
